/* rtl/lrns_pkg.sv */
// Shared types and constants for the least-resource node scorer.
// Holds the controller state enum and the command/status structs.
// No dependencies.
package lrns_pkg;

  // Width of the node score result (fixed by the interface)
  localparam int unsigned SCORE_W = 21;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } lrns_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture an accepted item
    logic check;      // feasibility check, load divider
    logic div_step;   // one restoring division step
    logic div_first;  // first step: compare without shift
    logic acc;        // add term into running sum
    logic emit;       // load output register, clear request state
  } lrns_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic skip;       // no division needed for this item
    logic last;       // captured item ends the request
    logic out_free;   // output register can take a result
  } lrns_sts_t;

endpackage

/* rtl/lrns_ctrl.sv */
// Controller for the least-resource node scorer.
// Sequences accept, check, division steps, accumulate and emit.
// Depends on lrns_pkg.
module lrns_ctrl
  import lrns_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lrns_sts_t sts_i,
  output lrns_cmd_t cmd_o
);

  localparam int unsigned STEPS = FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(STEPS);

  lrns_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic last_step;

  assign last_step = (cnt_q == CNT_W'(FRAC_BITS));

  // State and step counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: state_d = sts_i.skip ? ST_ACC : ST_DIV;
      ST_DIV:   if (last_step) state_d = ST_ACC;
      ST_ACC:   state_d = sts_i.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Step counter: cleared on check, advanced per division step
  always_comb begin
    cnt_d = cnt_q;
    if (state_q == ST_CHECK) begin
      cnt_d = '0;
    end else if (state_q == ST_DIV && !last_step) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: cmd_o.check = 1'b1;
      ST_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
      end
      ST_ACC:   cmd_o.acc  = 1'b1;
      ST_EMIT:  cmd_o.emit = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/lrns_dp.sv */
// Datapath for the least-resource node scorer: operand registers,
// restoring divider, saturating accumulator and output register.
// Depends on lrns_pkg.
module lrns_dp
  import lrns_pkg::*;
#(
  parameter int unsigned FRAC_BITS          = 16,
  parameter int unsigned MAX_RESOURCE_TYPES = 16,
  parameter int unsigned AMOUNT_BITS        = 40
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lrns_cmd_t              cmd_i,
  output lrns_sts_t              sts_o,
  input  logic [AMOUNT_BITS-1:0] requested_amount_i,
  input  logic [AMOUNT_BITS-1:0] available_amount_i,
  input  logic [AMOUNT_BITS-1:0] held_amount_i,
  input  logic                   last_resource_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SCORE_W-1:0]     fit_score_o,
  output logic                   infeasible_o
);

  localparam int unsigned TERM_W = FRAC_BITS + 1;
  localparam int unsigned ACC_W  = ((TERM_W > SCORE_W) ? TERM_W : SCORE_W) + 1;
  localparam longint unsigned CAP_FULL  = longint'(MAX_RESOURCE_TYPES) << FRAC_BITS;
  localparam longint unsigned SCORE_MAX = (longint'(1) << SCORE_W) - 1;
  localparam logic [SCORE_W-1:0] CAP =
    SCORE_W'((CAP_FULL < SCORE_MAX) ? CAP_FULL : SCORE_MAX);

  // Operand registers
  logic [AMOUNT_BITS-1:0] req_q, usable_q, rem_q;
  logic [AMOUNT_BITS-1:0] rem_d;
  logic                   last_q;
  logic [TERM_W-1:0]      quo_q, quo_d;

  // Request state
  logic [SCORE_W-1:0] score_sum_q, score_sum_d;
  logic               failed_q, failed_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [SCORE_W-1:0] fit_score_q;
  logic               infeasible_q;

  // Usable amount at the input: available minus held, clamped at zero
  logic [AMOUNT_BITS:0]   use_diff;
  logic [AMOUNT_BITS-1:0] usable_in;
  assign use_diff  = {1'b0, available_amount_i} - {1'b0, held_amount_i};
  assign usable_in = use_diff[AMOUNT_BITS] ? '0 : use_diff[AMOUNT_BITS-1:0];

  // Feasibility: usable minus requested, borrow means infeasible
  logic [AMOUNT_BITS:0] free_diff;
  logic                 over_req;
  logic                 usable_zero;
  assign free_diff   = {1'b0, usable_q} - {1'b0, req_q};
  assign over_req    = free_diff[AMOUNT_BITS];
  assign usable_zero = (usable_q == '0);

  // One restoring step: shift (except first), compare, subtract
  logic [AMOUNT_BITS:0] cand;
  logic [AMOUNT_BITS:0] cand_sub;
  logic                 q_bit;
  assign cand     = cmd_i.div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign cand_sub = cand - {1'b0, usable_q};
  assign q_bit    = !cand_sub[AMOUNT_BITS];

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.check) begin
      rem_d = free_diff[AMOUNT_BITS-1:0];
      quo_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d = q_bit ? cand_sub[AMOUNT_BITS-1:0] : cand[AMOUNT_BITS-1:0];
      quo_d = {quo_q[TERM_W-2:0], q_bit};
    end
  end

  // Saturating accumulate
  logic [ACC_W-1:0]   sum_w;
  logic [SCORE_W-1:0] sum_sat;
  assign sum_w   = ACC_W'(score_sum_q) + ACC_W'(quo_q);
  assign sum_sat = (sum_w > ACC_W'(CAP)) ? CAP : sum_w[SCORE_W-1:0];

  always_comb begin
    score_sum_d = score_sum_q;
    failed_d    = failed_q;
    if (cmd_i.check) begin
      failed_d = failed_q | over_req;
    end else if (cmd_i.acc) begin
      score_sum_d = sum_sat;
    end else if (cmd_i.emit) begin
      score_sum_d = '0;
      failed_d    = 1'b0;
    end
  end

  // Output register handshake
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign sts_o.skip = failed_q | over_req | usable_zero;
  assign sts_o.last = last_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_sum_q <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      score_sum_q <= score_sum_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= requested_amount_i;
      usable_q <= usable_in;
      last_q   <= last_resource_i;
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.emit) begin
      fit_score_q  <= failed_q ? '0 : score_sum_q;
      infeasible_q <= failed_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign fit_score_o  = fit_score_q;
  assign infeasible_o = infeasible_q;

`ifndef ASSERT_OFF
  // Running sum never passes the saturation cap
  a_sum_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    score_sum_q <= CAP)
    else $error("score sum above cap");

  // Partial remainder stays below the divisor between steps
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && !cmd_i.div_first) |-> (rem_q < usable_q))
    else $error("remainder not below divisor");

  // Request state is cleared after a result is emitted
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (score_sum_q == '0 && !failed_q))
    else $error("request state not cleared after emit");

  // Infeasible result always carries a zero score
  a_infeas_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && infeasible_q) |-> (fit_score_q == '0))
    else $error("infeasible result with nonzero score");
`endif

endmodule

/* rtl/least_resource_node_scorer.sv */
// Least-resource node scorer: scores one node for one resource request.
// One input item per resource type; one result per item marked last.
//
// Input channel (in_valid_i/in_ready_o): one resource type per item with the
// requested, available and held amounts and a last_resource flag.
// Output channel (out_valid_o/out_ready_i): fit_score_o (Q FRAC_BITS sum of
// free fractions, 0 when infeasible) and infeasible_o, once per request.
// Each item runs through accept, feasibility check, FRAC_BITS+1 restoring
// division steps (one quotient bit per cycle in a shared divider) and an
// accumulate step. Items that need no division (infeasible, zero usable,
// request already failed) go from the check straight to the accumulate step.
// The last item of a request then passes through an emit state that loads
// the output register once it is free.
// Reset clears the running sum, the failed flag and the output valid.
// A stalled receiver holds the result in the output register; the block
// keeps taking items and stalls only when a second result is ready to load.
// Depends on lrns_pkg, lrns_ctrl and lrns_dp.
module least_resource_node_scorer
  import lrns_pkg::*;
#(
  parameter int unsigned FRAC_BITS          = 16,
  parameter int unsigned MAX_RESOURCE_TYPES = 16,
  parameter int unsigned AMOUNT_BITS        = 40
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [AMOUNT_BITS-1:0] requested_amount_i,
  input  logic [AMOUNT_BITS-1:0] available_amount_i,
  input  logic [AMOUNT_BITS-1:0] held_amount_i,
  input  logic                   last_resource_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SCORE_W-1:0]     fit_score_o,
  output logic                   infeasible_o
);

  lrns_cmd_t cmd;
  lrns_sts_t sts;

  // Sequencer
  lrns_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Divider, accumulator and output register
  lrns_dp #(
    .FRAC_BITS          (FRAC_BITS),
    .MAX_RESOURCE_TYPES (MAX_RESOURCE_TYPES),
    .AMOUNT_BITS        (AMOUNT_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .requested_amount_i (requested_amount_i),
    .available_amount_i (available_amount_i),
    .held_amount_i      (held_amount_i),
    .last_resource_i    (last_resource_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .fit_score_o        (fit_score_o),
    .infeasible_o       (infeasible_o)
  );

endmodule
